// ----- rtl/ishm_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// IMU sample health monitor package
// Shared widths, register indexes, health codes and transaction payloads.
// ---------------------------------------------------------------------------
package ishm_pkg;

  localparam int TIME_BITS  = 48;
  localparam int AXIS_BITS  = 16;
  localparam int SEQ_BITS   = 16;
  localparam int CNT_BITS   = 32;
  localparam int THR_BITS   = 32;
  localparam int LIM_BITS   = 16;
  localparam int MAG_BITS   = 2 * AXIS_BITS;
  localparam int SUM_BITS   = MAG_BITS + 2;
  localparam int GCMP_BITS  = (AXIS_BITS > LIM_BITS) ? AXIS_BITS + 1 : LIM_BITS + 1;
  localparam int CFG_BITS   = (TIME_BITS > THR_BITS) ? TIME_BITS : THR_BITS;
  localparam int IDX_BITS   = 3;

  localparam logic [IDX_BITS-1:0] REG_ACCEL_MIN   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ACCEL_MAX   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_GYRO_LIMIT  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_RUN_LIMIT   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_STALE_AGE   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_TIMEOUT_AGE = 3'd5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

  localparam logic [THR_BITS-1:0]  RST_ACCEL_MIN   = 32'd16777216;
  localparam logic [THR_BITS-1:0]  RST_ACCEL_MAX   = 32'd3221225472;
  localparam logic [LIM_BITS-1:0]  RST_GYRO_LIMIT  = 16'd32767;
  localparam logic [LIM_BITS-1:0]  RST_RUN_LIMIT   = 16'd5;
  localparam logic [TIME_BITS-1:0] RST_STALE_AGE   = TIME_BITS'(40000);
  localparam logic [TIME_BITS-1:0] RST_TIMEOUT_AGE = TIME_BITS'(200000);

  typedef enum logic [2:0] {
    ST_NOT_INIT = 3'd0,
    ST_OK       = 3'd1,
    ST_READ_ERR = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_STALE    = 3'd4,
    ST_STUCK    = 3'd5,
    ST_INVALID  = 3'd6
  } health_t;

  typedef struct packed {
    logic                        kind;
    logic                        read_ok;
    logic                        sample_valid;
    logic signed [AXIS_BITS-1:0] accel_x;
    logic signed [AXIS_BITS-1:0] accel_y;
    logic signed [AXIS_BITS-1:0] accel_z;
    logic signed [AXIS_BITS-1:0] gyro_x;
    logic signed [AXIS_BITS-1:0] gyro_y;
    logic signed [AXIS_BITS-1:0] gyro_z;
    logic [TIME_BITS-1:0]        sample_stamp;
    logic [SEQ_BITS-1:0]         sample_seq;
    logic [TIME_BITS-1:0]        now_time;
  } item_t;

  typedef struct packed {
    health_t              health_state;
    logic [CNT_BITS-1:0]  read_error_count;
    logic [CNT_BITS-1:0]  sample_count;
    logic [CNT_BITS-1:0]  invalid_count;
    logic [CNT_BITS-1:0]  stuck_count;
    logic [CNT_BITS-1:0]  stale_count;
    logic [CNT_BITS-1:0]  timeout_count;
    logic [CNT_BITS-1:0]  identical_run;
    logic [TIME_BITS-1:0] last_good_time;
  } result_t;

  typedef struct packed {
    logic [THR_BITS-1:0]  accel_mag_sq_min;
    logic [THR_BITS-1:0]  accel_mag_sq_max;
    logic [LIM_BITS-1:0]  gyro_abs_limit;
    logic [LIM_BITS-1:0]  run_limit;
    logic [TIME_BITS-1:0] stale_age;
    logic [TIME_BITS-1:0] timeout_age;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    logic  plausible;
    item_t item;
  } stage_t;

  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
    return (v == '1) ? v : v + CNT_BITS'(1);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/imu_sample_health_monitor_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// IMU sample health monitor
// Six-lane sample checker with health state tracking and event counters.
// ---------------------------------------------------------------------------
// Path: input and lane registers, merge stage register, then the result register.
// Throughput: one transaction per cycle while rsp_stall is low; the state update in
//   the tracker stage closes the loop between consecutive transactions.
// Reset: rst clears state, counters and pipeline valids and loads the register
//   defaults; no clearing pass, ready on the first cycle after reset.
// ---------------------------------------------------------------------------
module imu_sample_health_monitor_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ishm_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [ishm_pkg::CFG_BITS-1:0] cfg_data,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire ishm_pkg::item_t               req,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output ishm_pkg::result_t                  rsp
);
  import ishm_pkg::*;

  cfg_t                cfg;
  logic                s1_valid;
  item_t               s1_item;
  logic                s1_load;
  logic                s2_ready;
  logic                out_ready;
  stage_t              s2;
  logic [MAG_BITS-1:0] sq_x, sq_y, sq_z;
  logic [2:0]          gyro_over;

  assign req_stall = s1_valid && !s2_ready;
  assign s1_load   = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_mag_sq_min <= RST_ACCEL_MIN;
      cfg.accel_mag_sq_max <= RST_ACCEL_MAX;
      cfg.gyro_abs_limit   <= RST_GYRO_LIMIT;
      cfg.run_limit        <= RST_RUN_LIMIT;
      cfg.stale_age        <= RST_STALE_AGE;
      cfg.timeout_age      <= RST_TIMEOUT_AGE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL_MIN:   cfg.accel_mag_sq_min <= cfg_data[THR_BITS-1:0];
        REG_ACCEL_MAX:   cfg.accel_mag_sq_max <= cfg_data[THR_BITS-1:0];
        REG_GYRO_LIMIT:  cfg.gyro_abs_limit   <= cfg_data[LIM_BITS-1:0];
        REG_RUN_LIMIT:   cfg.run_limit        <= cfg_data[LIM_BITS-1:0];
        REG_STALE_AGE:   cfg.stale_age        <= cfg_data[TIME_BITS-1:0];
        REG_TIMEOUT_AGE: cfg.timeout_age      <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
    if (s1_load) begin
      s1_item <= req;
    end
  end

  ishm_accel_lane u_lane_ax (.clk(clk), .en(s1_load), .axis(req.accel_x), .square(sq_x));
  ishm_accel_lane u_lane_ay (.clk(clk), .en(s1_load), .axis(req.accel_y), .square(sq_y));
  ishm_accel_lane u_lane_az (.clk(clk), .en(s1_load), .axis(req.accel_z), .square(sq_z));

  ishm_gyro_lane u_lane_gx (
    .clk(clk), .en(s1_load), .axis(req.gyro_x), .limit(cfg.gyro_abs_limit),
    .over(gyro_over[0])
  );
  ishm_gyro_lane u_lane_gy (
    .clk(clk), .en(s1_load), .axis(req.gyro_y), .limit(cfg.gyro_abs_limit),
    .over(gyro_over[1])
  );
  ishm_gyro_lane u_lane_gz (
    .clk(clk), .en(s1_load), .axis(req.gyro_z), .limit(cfg.gyro_abs_limit),
    .over(gyro_over[2])
  );

  ishm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_item   (s1_item),
    .sq_x      (sq_x),
    .sq_y      (sq_y),
    .sq_z      (sq_z),
    .gyro_over (gyro_over),
    .cfg       (cfg),
    .next_ready(out_ready),
    .ready     (s2_ready),
    .stage     (s2)
  );

  ishm_tracker u_tracker (
    .clk      (clk),
    .rst      (rst),
    .stage    (s2),
    .cfg      (cfg),
    .ready    (out_ready),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire

// ----- rtl/ishm_accel_lane.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Accelerometer lane
// Registered square of one signed accelerometer axis.
// ---------------------------------------------------------------------------
module ishm_accel_lane (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [ishm_pkg::AXIS_BITS-1:0] axis,
  output logic [ishm_pkg::MAG_BITS-1:0]             square
);
  import ishm_pkg::*;

  logic signed [MAG_BITS-1:0] prod;

  assign prod = axis * axis;

  always_ff @(posedge clk) begin
    if (en) begin
      square <= unsigned'(prod);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ishm_gyro_lane.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Gyroscope lane
// Registered over-limit flag for the magnitude of one signed gyro axis.
// ---------------------------------------------------------------------------
module ishm_gyro_lane (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [ishm_pkg::AXIS_BITS-1:0] axis,
  input  wire logic [ishm_pkg::LIM_BITS-1:0]        limit,
  output logic                                      over
);
  import ishm_pkg::*;

  logic [AXIS_BITS-1:0] mag;

  assign mag = axis[AXIS_BITS-1] ? unsigned'(-axis) : unsigned'(axis);

  always_ff @(posedge clk) begin
    if (en) begin
      over <= GCMP_BITS'(mag) > GCMP_BITS'(limit);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ishm_merge.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Lane merge stage
// Sums the accelerometer squares, checks the magnitude window and combines
// the gyro flags into one plausibility bit per transaction.
// ---------------------------------------------------------------------------
module ishm_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire ishm_pkg::item_t               in_item,
  input  wire logic [ishm_pkg::MAG_BITS-1:0] sq_x,
  input  wire logic [ishm_pkg::MAG_BITS-1:0] sq_y,
  input  wire logic [ishm_pkg::MAG_BITS-1:0] sq_z,
  input  wire logic [2:0]                    gyro_over,
  input  wire ishm_pkg::cfg_t                cfg,
  input  wire logic                          next_ready,
  output logic                               ready,
  output ishm_pkg::stage_t                   stage
);
  import ishm_pkg::*;

  logic [SUM_BITS-1:0] mag;
  logic                mag_ok;

  assign mag    = SUM_BITS'(sq_x) + SUM_BITS'(sq_y) + SUM_BITS'(sq_z);
  assign mag_ok = (mag >= SUM_BITS'(cfg.accel_mag_sq_min)) &&
                  (mag <= SUM_BITS'(cfg.accel_mag_sq_max));
  assign ready  = !stage.valid || next_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (ready) begin
      stage.valid <= in_valid;
    end
    if (ready && in_valid) begin
      stage.item      <= in_item;
      stage.plausible <= mag_ok && (gyro_over == 3'b000);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ishm_tracker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Health tracker
// Keeps health state, previous sample, counters and the result register.
// ---------------------------------------------------------------------------
module ishm_tracker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ishm_pkg::stage_t stage,
  input  wire ishm_pkg::cfg_t   cfg,
  output logic                  ready,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output ishm_pkg::result_t     rsp
);
  import ishm_pkg::*;

  health_t                     state_code, state_code_next;
  logic                        have_previous, have_previous_next;
  logic signed [AXIS_BITS-1:0] prev_axes [6];
  logic [TIME_BITS-1:0]        prev_stamp;
  logic [SEQ_BITS-1:0]         prev_seq;
  logic [TIME_BITS-1:0]        good_stamp, good_stamp_next;
  logic [CNT_BITS-1:0]         n_rd_err, n_rd_err_next;
  logic [CNT_BITS-1:0]         n_samples, n_samples_next;
  logic [CNT_BITS-1:0]         n_invalid, n_invalid_next;
  logic [CNT_BITS-1:0]         n_stuck, n_stuck_next;
  logic [CNT_BITS-1:0]         n_stale, n_stale_next;
  logic [CNT_BITS-1:0]         n_timeout, n_timeout_next;
  logic [CNT_BITS-1:0]         run, run_next;
  logic                        keep_prev;
  logic                        same;
  logic                        stuck;
  logic [TIME_BITS-1:0]        age;
  logic                        move;
  item_t                       it;

  assign it    = stage.item;
  assign ready = !rsp_valid || !rsp_stall;
  assign move  = stage.valid && ready;
  assign age   = it.now_time - good_stamp;
  assign same  = (it.accel_x == prev_axes[0]) && (it.accel_y == prev_axes[1]) &&
                 (it.accel_z == prev_axes[2]) && (it.gyro_x == prev_axes[3]) &&
                 (it.gyro_y == prev_axes[4]) && (it.gyro_z == prev_axes[5]);

  always_comb begin
    state_code_next    = state_code;
    have_previous_next = have_previous;
    good_stamp_next    = good_stamp;
    n_rd_err_next      = n_rd_err;
    n_samples_next     = n_samples;
    n_invalid_next     = n_invalid;
    n_stuck_next       = n_stuck;
    n_stale_next       = n_stale;
    n_timeout_next     = n_timeout;
    run_next           = run;
    keep_prev          = 1'b0;
    stuck              = 1'b0;
    if (it.kind == KIND_POLL) begin
      if (state_code != ST_NOT_INIT && have_previous) begin
        if (age > cfg.timeout_age) begin
          if (state_code != ST_TIMEOUT) begin
            n_timeout_next = sat_inc(n_timeout);
          end
          state_code_next = ST_TIMEOUT;
        end else if (age > cfg.stale_age) begin
          if (state_code != ST_STALE) begin
            n_stale_next = sat_inc(n_stale);
          end
          state_code_next = ST_STALE;
        end
      end
    end else if (!it.read_ok || !it.sample_valid) begin
      n_rd_err_next   = sat_inc(n_rd_err);
      state_code_next = ST_READ_ERR;
    end else begin
      n_samples_next = sat_inc(n_samples);
      if ((have_previous && it.sample_stamp < prev_stamp) || !stage.plausible) begin
        n_invalid_next  = sat_inc(n_invalid);
        state_code_next = ST_INVALID;
      end else begin
        keep_prev = 1'b1;
        if (have_previous) begin
          if (same || it.sample_seq == prev_seq) begin
            run_next = sat_inc(run);
            stuck    = run_next >= CNT_BITS'(cfg.run_limit);
          end else begin
            run_next = '0;
          end
        end
        if (stuck) begin
          n_stuck_next    = sat_inc(n_stuck);
          state_code_next = ST_STUCK;
        end else begin
          have_previous_next = 1'b1;
          good_stamp_next    = it.sample_stamp;
          state_code_next    = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_code    <= ST_NOT_INIT;
      have_previous <= 1'b0;
      good_stamp    <= '0;
      n_rd_err      <= '0;
      n_samples     <= '0;
      n_invalid     <= '0;
      n_stuck       <= '0;
      n_stale       <= '0;
      n_timeout     <= '0;
      run           <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (ready) begin
        rsp_valid <= stage.valid;
      end
      if (move) begin
        state_code    <= state_code_next;
        have_previous <= have_previous_next;
        good_stamp    <= good_stamp_next;
        n_rd_err      <= n_rd_err_next;
        n_samples     <= n_samples_next;
        n_invalid     <= n_invalid_next;
        n_stuck       <= n_stuck_next;
        n_stale       <= n_stale_next;
        n_timeout     <= n_timeout_next;
        run           <= run_next;
      end
    end
    if (move && keep_prev) begin
      prev_axes[0] <= it.accel_x;
      prev_axes[1] <= it.accel_y;
      prev_axes[2] <= it.accel_z;
      prev_axes[3] <= it.gyro_x;
      prev_axes[4] <= it.gyro_y;
      prev_axes[5] <= it.gyro_z;
      prev_stamp   <= it.sample_stamp;
      prev_seq     <= it.sample_seq;
    end
    if (move) begin
      rsp.health_state     <= state_code_next;
      rsp.read_error_count <= n_rd_err_next;
      rsp.sample_count     <= n_samples_next;
      rsp.invalid_count    <= n_invalid_next;
      rsp.stuck_count      <= n_stuck_next;
      rsp.stale_count      <= n_stale_next;
      rsp.timeout_count    <= n_timeout_next;
      rsp.identical_run    <= run_next;
      rsp.last_good_time   <= good_stamp_next;
    end
  end

  a_good_stamp_on_ok: assert property (@(posedge clk) disable iff (rst)
    (good_stamp != $past(good_stamp)) |-> (state_code == ST_OK))
    else $error("last good time moved without an ok sample");

  a_have_prev_sticks: assert property (@(posedge clk) disable iff (rst)
    have_previous |=> have_previous)
    else $error("good-sample flag dropped");

  a_no_return_init: assert property (@(posedge clk) disable iff (rst)
    (state_code != ST_NOT_INIT) |=> (state_code != ST_NOT_INIT))
    else $error("health state went back to not initialized");

  a_init_no_good: assert property (@(posedge clk) disable iff (rst)
    (state_code == ST_NOT_INIT) |-> !have_previous)
    else $error("good sample recorded while not initialized");

endmodule
`default_nettype wire
